/* hdl/mma_pkg.sv */
// Shared types and constants for the matrix multiply-accumulate block.
// Field widths of the stream items, item kind codes, register indexes and
// the control structs passed between the sequencer, the stores and the MAC unit.
`default_nettype none

package mma_pkg;

  // Item field widths
  localparam int KIND_W     = 2;
  localparam int IDX_W      = 3;
  localparam int OPV_W      = 16;
  localparam int START_W    = 40;
  localparam int SUM_W      = 40;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 2;

  // Packed stream widths, padded to whole bytes
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  // Size register value after reset
  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_LOAD_C = 2'd2,
    KIND_RUN    = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNERS = 2'd2;

  // Write enables of the three element stores
  typedef struct packed {
    logic a;
    logic b;
    logic c;
  } st_wen_t;

  // Control that travels with one multiply-accumulate step
  typedef struct packed {
    logic vld;    // step carries a product
    logic first;  // first inner index: start from the stored C element
    logic fin;    // last inner index: element complete after this step
  } mac_ctl_t;

endpackage

`default_nettype wire

/* hdl/mma_stores.sv */
// Element stores for A, B and C, one write port and one registered read port each.
// C entries carry valid bits so that an unwritten entry reads as zero.
// Depends on mma_pkg.
`default_nettype none

module mma_stores import mma_pkg::*; #(
  parameter int MAX_DIM       = 8,
  parameter int OPERAND_WIDTH = 16,
  parameter int ACCUM_WIDTH   = 40,
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire st_wen_t                         wen,
  input  wire logic [IW-1:0]                   wr_row,
  input  wire logic [IW-1:0]                   wr_col,
  input  wire logic signed [OPERAND_WIDTH-1:0] wr_op,
  input  wire logic signed [ACCUM_WIDTH-1:0]   wr_acc,
  input  wire logic                            rd_en,
  input  wire logic [IW-1:0]                   rd_row,
  input  wire logic [IW-1:0]                   rd_col,
  input  wire logic [IW-1:0]                   rd_k,
  output logic signed [OPERAND_WIDTH-1:0]      a_rd,
  output logic signed [OPERAND_WIDTH-1:0]      b_rd,
  output logic signed [ACCUM_WIDTH-1:0]        c_rd
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IW-1:0] row,
                                                input logic [IW-1:0] col);
    addr_of = ADDR_W'(int'(row) * MAX_DIM + int'(col));
  endfunction

  logic signed [OPERAND_WIDTH-1:0] a_mem [DEPTH];
  logic signed [OPERAND_WIDTH-1:0] b_mem [DEPTH];
  logic signed [ACCUM_WIDTH-1:0]   c_mem [DEPTH];
  logic [DEPTH-1:0]                c_vld_r;

  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] a_addr;
  logic [ADDR_W-1:0] b_addr;
  logic [ADDR_W-1:0] c_addr;

  logic signed [OPERAND_WIDTH-1:0] a_rd_r;
  logic signed [OPERAND_WIDTH-1:0] b_rd_r;
  logic signed [ACCUM_WIDTH-1:0]   c_rd_r;
  logic                            c_rdv_r;

  assign wr_addr = addr_of(wr_row, wr_col);
  assign a_addr  = addr_of(rd_row, rd_k);
  assign b_addr  = addr_of(rd_k, rd_col);
  assign c_addr  = addr_of(rd_row, rd_col);

  always_ff @(posedge clk) begin
    if (wen.a) begin
      a_mem[wr_addr] <= wr_op;
    end
    if (rd_en) begin
      a_rd_r <= a_mem[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wen.b) begin
      b_mem[wr_addr] <= wr_op;
    end
    if (rd_en) begin
      b_rd_r <= b_mem[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wen.c) begin
      c_mem[wr_addr] <= wr_acc;
    end
    if (rd_en) begin
      c_rd_r  <= c_mem[c_addr];
      c_rdv_r <= c_vld_r[c_addr];
    end
  end

  // Valid bits stand in for clearing C at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= '0;
    end else if (wen.c) begin
      c_vld_r[wr_addr] <= 1'b1;
    end
  end

  assign a_rd = a_rd_r;
  assign b_rd = b_rd_r;
  assign c_rd = c_rdv_r ? c_rd_r : '0;

endmodule

`default_nettype wire

/* hdl/mma_mac.sv */
// Shared multiply and saturating accumulate unit, two register stages.
// Depends on mma_pkg for the step control struct.
`default_nettype none

module mma_mac import mma_pkg::*; #(
  parameter int OPERAND_WIDTH = 16,
  parameter int ACCUM_WIDTH   = 40
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire mac_ctl_t                        ctl,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_op,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_op,
  input  wire logic signed [ACCUM_WIDTH-1:0]   c_base,
  output logic                                 res_vld,
  output logic signed [ACCUM_WIDTH-1:0]        res
);

  localparam int PW = 2 * OPERAND_WIDTH;
  localparam int SW = ((ACCUM_WIDTH > PW) ? ACCUM_WIDTH : PW) + 1;

  mac_ctl_t                      ctl_p_r;
  logic signed [PW-1:0]          prod_r;
  logic signed [ACCUM_WIDTH-1:0] base_r;
  logic signed [ACCUM_WIDTH-1:0] acc_r;
  logic                          res_vld_r;

  logic signed [ACCUM_WIDTH-1:0] acc_base;
  logic signed [SW-1:0]          sum_w;
  logic                          fits;
  logic signed [ACCUM_WIDTH-1:0] acc_nxt;

  // Exact sum in a wide word, then clamp to the accumulator range
  always_comb begin
    acc_base = ctl_p_r.first ? base_r : acc_r;
    sum_w    = SW'(acc_base) + SW'(prod_r);
    fits     = (sum_w[SW-1:ACCUM_WIDTH-1] == {(SW-ACCUM_WIDTH+1){sum_w[SW-1]}});
    acc_nxt  = fits ? sum_w[ACCUM_WIDTH-1:0]
                    : {sum_w[SW-1], {(ACCUM_WIDTH-1){~sum_w[SW-1]}}};
  end

  always_ff @(posedge clk) begin
    prod_r <= a_op * b_op;
    base_r <= c_base;
    if (ctl_p_r.vld) begin
      acc_r <= acc_nxt;
    end
    if (!rst_n) begin
      ctl_p_r   <= '0;
      res_vld_r <= 1'b0;
    end else begin
      ctl_p_r   <= ctl;
      res_vld_r <= ctl_p_r.vld & ctl_p_r.fin;
    end
  end

  assign res_vld = res_vld_r;
  assign res     = acc_r;

endmodule

`default_nettype wire

/* hdl/matrix_multiply_accumulate_top.sv */
// Matrix multiply-accumulate, C += A * B, top level with the sequencer.
// Depends on mma_pkg, mma_stores and mma_mac.
//
// Use: write the three size registers (rows, columns, inners) on the cfg
// port while the block is idle; cfg_ready is always high. Stream load items
// on the in_ channel, kind in in_tuser: load A, load B or load C element at
// (first_index, second_index). Loads outside the configured sizes are dropped.
// A run item walks every C element in row-major order, adds the sum of
// A(r,k)*B(k,c) over the inner index with a saturating 40-bit accumulator,
// writes it back into C and emits it on the out_ channel; out_tlast marks the
// final element.
// Throughput: loads are accepted back to back while idle. A run keeps in_tready
// low until its final element is loaded for output: one multiply-accumulate per
// cycle through the single shared MAC unit while the output slot is free, plus a
// wait per element to read the stores and drain its pipeline.
// Reset: size registers go to 8 and C reads as zero; A and B hold garbage
// until written. When the receiver stalls, hold the finished element in the
// output register and wait at the start of the next element until it is taken.
`default_nettype none

module matrix_multiply_accumulate_top import mma_pkg::*; #(
  parameter int MAX_DIM       = 8,
  parameter int OPERAND_WIDTH = 16,
  parameter int ACCUM_WIDTH   = 40
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input items
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [2:0] first_index, [5:3] second_index, [21:6] operand_value,
  // [61:22] start_value, [63:62] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  wire logic [KIND_W-1:0]     in_tuser,
  // Result items
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [2:0] out_row, [5:3] out_column, [45:6] sum_value, [47:46] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast,
  // Configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int LW = (ACCUM_WIDTH > START_W) ? ACCUM_WIDTH : START_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN
  } state_t;

  // Clamp a size register to 1..MAX_DIM
  function automatic logic [CFG_W-1:0] dim_of(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      dim_of = CFG_W'(1);
    end else if (v > CFG_W'(MAX_DIM)) begin
      dim_of = CFG_W'(MAX_DIM);
    end else begin
      dim_of = v;
    end
  endfunction

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] rows_r, rows_nxt;
  logic [CFG_W-1:0] cols_r, cols_nxt;
  logic [CFG_W-1:0] inners_r, inners_nxt;
  logic [IW-1:0]    r_r, r_nxt;
  logic [IW-1:0]    c_r, c_nxt;
  logic [IW-1:0]    k_r, k_nxt;
  mac_ctl_t         issue;
  mac_ctl_t         ctl_rd_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;
  logic [IDX_W-1:0]     out_row_r;
  logic [IDX_W-1:0]     out_col_r;
  logic [SUM_W-1:0]     out_sum_r;
  logic                 out_last_r;

  // Input decode
  kind_t                           in_kind;
  logic [IDX_W-1:0]                in_fi;
  logic [IDX_W-1:0]                in_si;
  logic signed [OPV_W-1:0]         in_opv;
  logic signed [START_W-1:0]       in_start;
  logic signed [OPERAND_WIDTH-1:0] opv_op;
  logic signed [LW-1:0]            start_ext;
  logic signed [ACCUM_WIDTH-1:0]   start_sat;
  logic                            in_accept;

  logic [CFG_W-1:0] nr, nc, ni;
  logic             fi_in_rows, fi_in_inners, si_in_inners, si_in_cols;
  logic             r_last, c_last, k_last;

  st_wen_t                         st_wen;
  logic                            wb;
  logic [IW-1:0]                   wr_row, wr_col;
  logic signed [ACCUM_WIDTH-1:0]   wr_acc;
  logic signed [OPERAND_WIDTH-1:0] a_rd, b_rd;
  logic signed [ACCUM_WIDTH-1:0]   c_rd;
  logic                            mac_res_vld;
  logic signed [ACCUM_WIDTH-1:0]   mac_res;

  assign in_kind   = kind_t'(in_tuser);
  assign in_fi     = in_tdata[IDX_W-1:0];
  assign in_si     = in_tdata[2*IDX_W-1:IDX_W];
  assign in_opv    = signed'(in_tdata[2*IDX_W +: OPV_W]);
  assign in_start  = signed'(in_tdata[2*IDX_W+OPV_W +: START_W]);
  assign opv_op    = OPERAND_WIDTH'(in_opv);
  assign start_ext = LW'(in_start);
  assign start_sat =
    (start_ext[LW-1:ACCUM_WIDTH-1] == {(LW-ACCUM_WIDTH+1){start_ext[LW-1]}})
      ? start_ext[ACCUM_WIDTH-1:0]
      : {start_ext[LW-1], {(ACCUM_WIDTH-1){~start_ext[LW-1]}}};

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;

  assign nr = dim_of(rows_r);
  assign nc = dim_of(cols_r);
  assign ni = dim_of(inners_r);

  assign fi_in_rows   = CFG_W'(in_fi) < nr;
  assign fi_in_inners = CFG_W'(in_fi) < ni;
  assign si_in_inners = CFG_W'(in_si) < ni;
  assign si_in_cols   = CFG_W'(in_si) < nc;

  assign r_last = (CFG_W'(r_r) == nr - CFG_W'(1));
  assign c_last = (CFG_W'(c_r) == nc - CFG_W'(1));
  assign k_last = (CFG_W'(k_r) == ni - CFG_W'(1));

  // Store writes: loads while idle, C write-back when an element completes
  assign wb       = (state_r == S_DRAIN) & mac_res_vld;
  assign st_wen.a = in_accept & (in_kind == KIND_LOAD_A) & fi_in_rows & si_in_inners;
  assign st_wen.b = in_accept & (in_kind == KIND_LOAD_B) & fi_in_inners & si_in_cols;
  assign st_wen.c = (in_accept & (in_kind == KIND_LOAD_C) & fi_in_rows & si_in_cols) | wb;
  assign wr_row   = wb ? r_r : in_fi[IW-1:0];
  assign wr_col   = wb ? c_r : in_si[IW-1:0];
  assign wr_acc   = wb ? mac_res : start_sat;

  // Sequencer: walk r, c, k and feed the MAC unit one step per cycle while issuing, unless held for the output slot
  always_comb begin
    state_nxt  = state_r;
    r_nxt      = r_r;
    c_nxt      = c_r;
    k_nxt      = k_r;
    issue      = '0;
    out_load   = 1'b0;
    rows_nxt   = rows_r;
    cols_nxt   = cols_r;
    inners_nxt = inners_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS:   rows_nxt   = cfg_data;
        CFG_COLS:   cols_nxt   = cfg_data;
        CFG_INNERS: inners_nxt = cfg_data;
        default:    ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept && in_kind == KIND_RUN) begin
          r_nxt     = '0;
          c_nxt     = '0;
          k_nxt     = '0;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        // Hold at the start of an element until the output slot is free
        if (k_r != '0 || !out_valid_r || out_tready) begin
          issue.vld   = 1'b1;
          issue.first = (k_r == '0);
          issue.fin   = k_last;
          if (k_last) begin
            state_nxt = S_DRAIN;
          end else begin
            k_nxt = k_r + IW'(1);
          end
        end
      end
      S_DRAIN: begin
        if (mac_res_vld) begin
          out_load = 1'b1;
          k_nxt    = '0;
          if (c_last) begin
            c_nxt = '0;
            if (r_last) begin
              state_nxt = S_IDLE;
            end else begin
              r_nxt     = r_r + IW'(1);
              state_nxt = S_ISSUE;
            end
          end else begin
            c_nxt     = c_r + IW'(1);
            state_nxt = S_ISSUE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    // Output payload, no reset needed
    if (out_load) begin
      out_row_r  <= IDX_W'(r_r);
      out_col_r  <= IDX_W'(c_r);
      out_sum_r  <= SUM_W'(mac_res);
      out_last_r <= r_last & c_last;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_r      <= DIM_RESET;
      cols_r      <= DIM_RESET;
      inners_r    <= DIM_RESET;
      r_r         <= '0;
      c_r         <= '0;
      k_r         <= '0;
      ctl_rd_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      inners_r    <= inners_nxt;
      r_r         <= r_nxt;
      c_r         <= c_nxt;
      k_r         <= k_nxt;
      ctl_rd_r    <= issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_sum_r, out_col_r, out_row_r};
  assign out_tlast  = out_last_r;

  mma_stores #(
    .MAX_DIM       (MAX_DIM),
    .OPERAND_WIDTH (OPERAND_WIDTH),
    .ACCUM_WIDTH   (ACCUM_WIDTH)
  ) u_stores (
    .clk    (clk),
    .rst_n  (rst_n),
    .wen    (st_wen),
    .wr_row (wr_row),
    .wr_col (wr_col),
    .wr_op  (opv_op),
    .wr_acc (wr_acc),
    .rd_en  (issue.vld),
    .rd_row (r_r),
    .rd_col (c_r),
    .rd_k   (k_r),
    .a_rd   (a_rd),
    .b_rd   (b_rd),
    .c_rd   (c_rd)
  );

  mma_mac #(
    .OPERAND_WIDTH (OPERAND_WIDTH),
    .ACCUM_WIDTH   (ACCUM_WIDTH)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_rd_r),
    .a_op    (a_rd),
    .b_op    (b_rd),
    .c_base  (c_rd),
    .res_vld (mac_res_vld),
    .res     (mac_res)
  );

  // A finished element never overwrites one that is still waiting
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r)
    else $error("result loaded while output register busy");

  // The MAC unit completes an element only while the sequencer waits for it
  a_res_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mac_res_vld |-> (state_r == S_DRAIN))
    else $error("MAC result outside drain");

  // After the final element the block returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && r_last && c_last) |=> (state_r == S_IDLE))
    else $error("sequencer busy after final element");

endmodule

`default_nettype wire

/* tb/sv/matrix_multiply_accumulate_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for matrix_multiply_accumulate_top (C += A * B).
// Holds its own shadow of the A, B and C stores and the size registers.
// Depends on mma_pkg and the block's RTL only.

module matrix_multiply_accumulate_top_tb;
  import mma_pkg::*;

  localparam int MAX_DIM = 8;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int SHOWN_MISMATCHES = 10;
  // Index past the register list; the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [OPV_W-1:0] OPV_MAX = {1'b0, {(OPV_W-1){1'b1}}};
  localparam logic signed [OPV_W-1:0] OPV_MIN = {1'b1, {(OPV_W-1){1'b0}}};

  // One input item, unpacked into its fields
  typedef struct {
    kind_t                     kind;
    logic [IDX_W-1:0]          fi;
    logic [IDX_W-1:0]          si;
    logic signed [OPV_W-1:0]   opv;
    logic signed [START_W-1:0] start;
  } gemm_item_t;

  // One emitted C element
  typedef struct {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [SUM_W-1:0] sum;
    logic                    is_last;
  } c_elem_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  matrix_multiply_accumulate_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow of the block: element stores and raw size registers
  logic signed [OPV_W-1:0] a_shadow [STORE_DEPTH];
  logic signed [OPV_W-1:0] b_shadow [STORE_DEPTH];
  logic signed [SUM_W-1:0] c_shadow [STORE_DEPTH];
  logic [CFG_W-1:0]        rows_reg_sh;
  logic [CFG_W-1:0]        cols_reg_sh;
  logic [CFG_W-1:0]        inners_reg_sh;

  gemm_item_t  pending_items [$];   // items waiting for the driver
  c_elem_t     c_elem_expect [$];   // C elements predicted, not yet seen
  gemm_item_t  on_bus;              // item currently presented on in_
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;

  // Generator view of the sizes, and which A/B entries hold a value, so that
  // no run ever reads an entry that was never written
  int unsigned gen_rows = MAX_DIM;
  int unsigned gen_cols = MAX_DIM;
  int unsigned gen_inners = MAX_DIM;
  bit          a_loaded [STORE_DEPTH];
  bit          b_loaded [STORE_DEPTH];

  // Zero reads as one, anything past the store size as the store size
  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Apply one accepted item to the shadow; a run pushes every C element
  task automatic accumulate_item(input gemm_item_t it);
    int unsigned nr, nc, ni, idx;
    longint acc;
    c_elem_t e;
    nr = eff_dim(rows_reg_sh);
    nc = eff_dim(cols_reg_sh);
    ni = eff_dim(inners_reg_sh);
    case (it.kind)
      KIND_LOAD_A: begin
        if (it.fi < nr && it.si < ni) a_shadow[it.fi * MAX_DIM + it.si] = it.opv;
      end
      KIND_LOAD_B: begin
        if (it.fi < ni && it.si < nc) b_shadow[it.fi * MAX_DIM + it.si] = it.opv;
      end
      KIND_LOAD_C: begin
        if (it.fi < nr && it.si < nc) c_shadow[it.fi * MAX_DIM + it.si] = it.start;
      end
      KIND_RUN: begin
        for (int unsigned r = 0; r < nr; r++) begin
          for (int unsigned c = 0; c < nc; c++) begin
            idx = r * MAX_DIM + c;
            acc = c_shadow[idx];
            // Inner index ascending, saturate after every addition
            for (int unsigned k = 0; k < ni; k++) begin
              acc = acc + longint'(a_shadow[r * MAX_DIM + k]) *
                          longint'(b_shadow[k * MAX_DIM + c]);
              if (acc > SUM_MAX) acc = SUM_MAX;
              if (acc < SUM_MIN) acc = SUM_MIN;
            end
            c_shadow[idx] = acc[SUM_W-1:0];
            e.row = r[IDX_W-1:0];
            e.col = c[IDX_W-1:0];
            e.sum = acc[SUM_W-1:0];
            e.is_last = (r == nr - 1) && (c == nc - 1);
            c_elem_expect.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Driver: predict on every accepted item, then present the next one or
  // hold off for a random burst. Valid never drops while an item is waiting.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
      rows_reg_sh = DIM_RESET;
      cols_reg_sh = DIM_RESET;
      inners_reg_sh = DIM_RESET;
      for (int i = 0; i < STORE_DEPTH; i++) c_shadow[i] = '0;
    end else begin
      // Track size register writes; they only happen while the block is idle
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROWS:   rows_reg_sh = cfg_data;
          CFG_COLS:   cols_reg_sh = cfg_data;
          CFG_INNERS: inners_reg_sh = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) accumulate_item(on_bus);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0 && idle_on && $urandom_range(0, 3) == 0) begin
          // Hold off for a random burst
          send_gap = $urandom_range(0, 9);
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          on_bus = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {2'b00, on_bus.start, on_bus.opv, on_bus.si, on_bus.fi};
          in_tuser <= on_bus.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall in random bursts while idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: compare each accepted C element with the oldest prediction
  always @(posedge clk) begin : result_check
    c_elem_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (c_elem_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("unexpected C element: row %0d col %0d sum %0d last %0b",
                   out_tdata[2:0], out_tdata[5:3], $signed(out_tdata[45:6]), out_tlast);
      end else begin
        want = c_elem_expect.pop_front();
        if (out_tdata[2:0] !== want.row || out_tdata[5:3] !== want.col ||
            $signed(out_tdata[45:6]) !== want.sum || out_tlast !== want.is_last) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("C element: expected row %0d col %0d sum %0d last %0b, got row %0d col %0d sum %0d last %0b",
                     want.row, want.col, want.sum, want.is_last,
                     out_tdata[2:0], out_tdata[5:3], $signed(out_tdata[45:6]), out_tlast);
        end
      end
    end
  end

  // Watchdog: end the run if it hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("matrix_multiply_accumulate_top: mismatch");
    $finish;
  end

  function automatic logic signed [OPV_W-1:0] rand_operand();
    case ($urandom_range(0, 7))
      0:       return OPV_MAX;
      1:       return OPV_MIN;
      default: return OPV_W'($urandom);
    endcase
  endfunction

  // Bias toward the accumulator ends so that runs hit saturation
  function automatic logic signed [START_W-1:0] rand_start();
    case ($urandom_range(0, 7))
      0:       return SUM_MAX;
      1:       return SUM_MIN;
      2:       return SUM_MAX - START_W'($urandom);
      3:       return SUM_MIN + START_W'($urandom);
      4:       return START_W'($signed(16'($urandom)));
      default: return START_W'({$urandom, $urandom});
    endcase
  endfunction

  task automatic queue_item(input kind_t kind, input logic [IDX_W-1:0] fi,
                            input logic [IDX_W-1:0] si, input logic signed [OPV_W-1:0] opv,
                            input logic signed [START_W-1:0] start);
    gemm_item_t it;
    it.kind = kind;
    it.fi = fi;
    it.si = si;
    it.opv = opv;
    it.start = start;
    if (kind == KIND_LOAD_A && fi < gen_rows && si < gen_inners)
      a_loaded[fi * MAX_DIM + si] = 1'b1;
    if (kind == KIND_LOAD_B && fi < gen_inners && si < gen_cols)
      b_loaded[fi * MAX_DIM + si] = 1'b1;
    pending_items.push_back(it);
  endtask

  task automatic queue_load(input kind_t kind, input int unsigned fi, input int unsigned si);
    queue_item(kind, fi[IDX_W-1:0], si[IDX_W-1:0], rand_operand(), rand_start());
  endtask

  // Write every A and B entry the next run reads that holds no value yet
  task automatic load_missing_operands();
    for (int unsigned r = 0; r < gen_rows; r++)
      for (int unsigned k = 0; k < gen_inners; k++)
        if (!a_loaded[r * MAX_DIM + k]) queue_load(KIND_LOAD_A, r, k);
    for (int unsigned k = 0; k < gen_inners; k++)
      for (int unsigned c = 0; c < gen_cols; c++)
        if (!b_loaded[k * MAX_DIM + c]) queue_load(KIND_LOAD_B, k, c);
  endtask

  // Mostly in-range loads with random content, some stray loads, some runs
  task automatic queue_random_items(input int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 22)
        queue_load(KIND_LOAD_A, $urandom_range(0, gen_rows - 1), $urandom_range(0, gen_inners - 1));
      else if (pick < 44)
        queue_load(KIND_LOAD_B, $urandom_range(0, gen_inners - 1), $urandom_range(0, gen_cols - 1));
      else if (pick < 62)
        queue_load(KIND_LOAD_C, $urandom_range(0, gen_rows - 1), $urandom_range(0, gen_cols - 1));
      else if (pick < 82)
        queue_load(kind_t'($urandom_range(0, 2)), $urandom_range(0, 7), $urandom_range(0, 7));
      else
        queue_load(KIND_RUN, $urandom_range(0, 7), $urandom_range(0, 7));
    end
  endtask

  // Call at a rising edge; returns at the accepting edge with valid still high
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_sizes(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                           input logic [CFG_W-1:0] inners);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_INNERS, inners);
    cfg_valid <= 1'b0;
    gen_rows = eff_dim(rows);
    gen_cols = eff_dim(cols);
    gen_inners = eff_dim(inners);
  endtask

  // Wait until every item is taken and every C element has come out, then
  // let a stray trailing load settle before touching the registers
  task automatic wait_drain();
    while (pending_items.size() != 0 || in_tvalid || c_elem_expect.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                              input logic [CFG_W-1:0] inners, input int unsigned count,
                              input bit quiet);
    idle_on = !quiet && ($urandom_range(0, 3) != 0);
    set_sizes(rows, cols, inners);
    load_missing_operands();
    queue_random_items(count);
    queue_load(KIND_RUN, $urandom_range(0, 7), $urandom_range(0, 7));
    wait_drain();
  endtask

  initial begin : stimulus
    for (int i = 0; i < STORE_DEPTH; i++) begin
      a_loaded[i] = 1'b0;
      b_loaded[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 2x2 result, one inner step. Drive the C ends into saturation
    // both ways, use the operand extremes, drop stray loads, run twice.
    idle_on = 1'b1;
    write_reg(CFG_SPARE, 4'hA);
    set_sizes(4'd2, 4'd2, 4'd1);
    queue_item(KIND_LOAD_A, 3'd0, 3'd0, OPV_MIN, rand_start());
    queue_item(KIND_LOAD_A, 3'd1, 3'd0, OPV_MAX, rand_start());
    queue_item(KIND_LOAD_B, 3'd0, 3'd0, OPV_MIN, rand_start());
    queue_item(KIND_LOAD_B, 3'd0, 3'd1, OPV_MAX, rand_start());
    queue_item(KIND_LOAD_C, 3'd0, 3'd0, rand_operand(), SUM_MAX);
    queue_item(KIND_LOAD_C, 3'd0, 3'd1, rand_operand(), SUM_MIN);
    queue_item(KIND_LOAD_C, 3'd1, 3'd0, rand_operand(), '0);
    queue_item(KIND_LOAD_C, 3'd1, 3'd1, rand_operand(), -40'sd1);
    // Out of range for the current sizes: must leave the stores alone
    queue_item(KIND_LOAD_A, 3'd7, 3'd7, OPV_MAX, SUM_MAX);
    queue_item(KIND_LOAD_B, 3'd7, 3'd0, OPV_MIN, SUM_MIN);
    queue_item(KIND_LOAD_C, 3'd2, 3'd7, OPV_MAX, SUM_MAX);
    queue_item(KIND_LOAD_A, 3'd0, 3'd1, OPV_MAX, SUM_MIN);
    queue_item(KIND_RUN, 3'd7, 3'd7, OPV_MIN, SUM_MAX);
    // A second run adds A*B into C again
    queue_item(KIND_RUN, 3'd0, 3'd0, OPV_MAX, SUM_MIN);
    wait_drain();

    // Random phases; register values outside 1..8 clamp in the block
    random_phase(4'd0, 4'd9, 4'd2, 18, 1'b0);
    random_phase(4'd8, 4'd8, 4'd1, 18, 1'b0);
    random_phase(4'd1, 4'd1, 4'd8, 18, 1'b0);
    random_phase(4'd15, 4'd3, 4'd0, 18, 1'b0);
    random_phase(4'd3, 4'd4, 4'd5, 18, 1'b0);
    // Final stretch runs at full rate on both sides
    random_phase(4'd2, 4'd3, 4'd3, 18, 1'b1);

    if (mismatches == 0) begin
      $display("matrix_multiply_accumulate_top: match");
    end else begin
      $display("matrix_multiply_accumulate_top: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/mma_pkg.sv
hdl/mma_stores.sv
hdl/mma_mac.sv
hdl/matrix_multiply_accumulate_top.sv
tb/sv/matrix_multiply_accumulate_top_tb.sv
